// ===== rtl/itrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrg_pkg
// Shared types and constants for the three-channel interval timer.
// ----------------------------------------------------------------------------
package itrg_pkg;

  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned CH_W = 2;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned PERIOD_W = COUNT_W + 1 + SCALE_W - 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd58254;

  localparam logic [1:0] PORT_CMD    = 2'd3;
  localparam logic [1:0] CH_READBACK = 2'd3;
  localparam logic [1:0] ACC_LATCH   = 2'd0;
  localparam logic [1:0] ACC_LOHI    = 2'd3;
  localparam logic [2:0] MODE_RATE   = 3'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    IRQ_NONE  = 2'd0,
    IRQ_RAISE = 2'd1,
    IRQ_PULSE = 2'd2
  } irq_action_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_READBACK = 3'd1,
    ERR_LATCH    = 3'd2,
    ERR_BCD      = 3'd3,
    ERR_ACCESS   = 3'd4
  } err_t;

  typedef struct packed {
    op_t               operation;
    logic [1:0]        port;
    logic [7:0]        value;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    err_t              error_code;
    logic [TIME_W-1:0] time_left;
    irq_action_t       irq_action;
  } result_t;

endpackage

// ===== rtl/itrg_period.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrg_period
// Holds the scale register and the registered channel 0 period.
// ----------------------------------------------------------------------------
module itrg_period (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [itrg_pkg::SCALE_W-1:0]       cfg_wdata,
  input  logic [itrg_pkg::COUNT_W-1:0]       count0_next,
  output logic [itrg_pkg::PERIOD_W-1:0]      period
);

  localparam int unsigned CNT_W = itrg_pkg::COUNT_W + 1;
  localparam int unsigned PROD_W = CNT_W + itrg_pkg::SCALE_W;

  logic [itrg_pkg::SCALE_W-1:0] scale;
  logic [itrg_pkg::SCALE_W-1:0] scale_next;
  logic [CNT_W-1:0]             cnt;
  logic [PROD_W-1:0]            prod;

  assign scale_next = cfg_wen ? cfg_wdata : scale;
  // zero count means the full 2^16 counts
  assign cnt = (count0_next == '0) ? {1'b1, {itrg_pkg::COUNT_W{1'b0}}}
                                   : {1'b0, count0_next};
  assign prod = PROD_W'(cnt) * PROD_W'(scale_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= itrg_pkg::SCALE_RESET;
      period <= itrg_pkg::PERIOD_W'(itrg_pkg::SCALE_RESET);
    end else begin
      scale  <= scale_next;
      period <= prod[PROD_W-1:16];
    end
  end

endmodule

// ===== rtl/itrg_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrg_core
// Channel state, command and data decode, and channel 0 interval check.
// ----------------------------------------------------------------------------
module itrg_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  itrg_pkg::item_t                item,
  input  logic [itrg_pkg::PERIOD_W-1:0]  period,
  output itrg_pkg::result_t              result,
  output logic [itrg_pkg::COUNT_W-1:0]   count0_next
);

  localparam int unsigned NCH = itrg_pkg::NUM_CHANNELS;
  localparam int unsigned TW = itrg_pkg::TIME_W;
  localparam int unsigned CH_IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

  logic [2:0]                  op_mode      [NCH];
  logic [1:0]                  acc_mode     [NCH];
  logic                        lo_loaded    [NCH];
  logic [itrg_pkg::COUNT_W-1:0] reload      [NCH];
  logic                        running      [NCH];
  logic [TW-1:0]               last_irq;

  logic [2:0]                  op_mode_next   [NCH];
  logic [1:0]                  acc_mode_next  [NCH];
  logic                        lo_loaded_next [NCH];
  logic [itrg_pkg::COUNT_W-1:0] reload_next   [NCH];
  logic                        running_next   [NCH];
  logic [TW-1:0]               last_irq_next;

  logic [1:0]    cmd_ch;
  logic [1:0]    cmd_acc;
  logic [2:0]    cmd_mode;
  logic [CH_IDX_W-1:0] cmd_idx;
  logic [CH_IDX_W-1:0] port_idx;
  logic [TW-1:0] period_w;
  logic [TW-1:0] elapsed;

  assign cmd_ch   = item.value[7:6];
  assign cmd_acc  = item.value[5:4];
  assign cmd_mode = item.value[3:1];
  assign cmd_idx  = CH_IDX_W'(cmd_ch);
  assign port_idx = CH_IDX_W'(item.port);
  assign period_w = TW'(period);
  assign elapsed  = item.now - last_irq;
  assign count0_next = reload_next[0];

  always_comb begin
    op_mode_next   = op_mode;
    acc_mode_next  = acc_mode;
    lo_loaded_next = lo_loaded;
    reload_next    = reload;
    running_next   = running;
    last_irq_next  = last_irq;
    result.irq_action = itrg_pkg::IRQ_NONE;
    result.error_code = itrg_pkg::ERR_OK;
    result.time_left  = '0;
    if (item.operation == itrg_pkg::OP_QUERY) begin
      if (running[0]) begin
        if (elapsed >= period_w) begin
          last_irq_next     = item.now;
          result.time_left  = period_w;
          result.irq_action = itrg_pkg::IRQ_PULSE;
        end else begin
          result.time_left = period_w - elapsed;
        end
      end else begin
        result.time_left = '1;
      end
    end else if (item.port == itrg_pkg::PORT_CMD) begin
      if (cmd_ch == itrg_pkg::CH_READBACK) begin
        result.error_code = itrg_pkg::ERR_READBACK;
      end else if (cmd_acc == itrg_pkg::ACC_LATCH) begin
        result.error_code = itrg_pkg::ERR_LATCH;
      end else if (item.value[0]) begin
        result.error_code = itrg_pkg::ERR_BCD;
      end else if (cmd_ch < 2'(NCH)) begin
        acc_mode_next[cmd_idx]  = cmd_acc;
        op_mode_next[cmd_idx]   = cmd_mode;
        lo_loaded_next[cmd_idx] = 1'b0;
        if (cmd_mode == itrg_pkg::MODE_RATE && cmd_ch == 2'd0) begin
          result.irq_action = itrg_pkg::IRQ_RAISE;
        end
      end
    end else if (item.port < 2'(NCH)) begin
      if (acc_mode[port_idx] != itrg_pkg::ACC_LOHI) begin
        result.error_code = itrg_pkg::ERR_ACCESS;
      end else if (lo_loaded[port_idx]) begin
        reload_next[port_idx]    = {item.value, reload[port_idx][7:0]};
        running_next[port_idx]   = 1'b1;
        lo_loaded_next[port_idx] = 1'b0;
        if (item.port == 2'd0) begin
          last_irq_next = item.now;
        end
      end else begin
        reload_next[port_idx]    = itrg_pkg::COUNT_W'(item.value);
        lo_loaded_next[port_idx] = 1'b1;
      end
    end
    if (!fire) begin
      op_mode_next   = op_mode;
      acc_mode_next  = acc_mode;
      lo_loaded_next = lo_loaded;
      reload_next    = reload;
      running_next   = running;
      last_irq_next  = last_irq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        op_mode[i]   <= '0;
        acc_mode[i]  <= '0;
        lo_loaded[i] <= 1'b0;
        reload[i]    <= '0;
        running[i]   <= 1'b0;
      end
      last_irq <= '0;
    end else begin
      op_mode   <= op_mode_next;
      acc_mode  <= acc_mode_next;
      lo_loaded <= lo_loaded_next;
      reload    <= reload_next;
      running   <= running_next;
      last_irq  <= last_irq_next;
    end
  end

endmodule

// ===== rtl/interval_timer_rate_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_timer_rate_generator
// Three-channel interval timer: command/data port writes and channel 0
// next-interrupt queries, one result per transfer.
// A result passes the input register, then the result register, before it
// can transfer out. Throughput: one item per cycle while the output is not
// held, set by the state update in the core; a held output stalls the input.
// Reset (rst, synchronous): all channels idle and unprogrammed, scale 58254.
// ----------------------------------------------------------------------------
module interval_timer_rate_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [itrg_pkg::SCALE_W-1:0]  cfg_wdata,  // period_scale
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [79:0]                   s_tdata,    // port[1:0], value[9:2], now[73:10]
  input  logic                          s_tuser,    // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata     // irq_action[1:0], time_left[65:2],
                                                    // error_code[68:66]
);

  itrg_pkg::item_t   item;
  logic              item_valid;
  logic              fire;
  itrg_pkg::result_t result;
  itrg_pkg::result_t result_q;
  logic [itrg_pkg::COUNT_W-1:0]  count0_next;
  logic [itrg_pkg::PERIOD_W-1:0] period;

  assign fire     = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.operation <= itrg_pkg::op_t'(s_tuser);
      item.port      <= s_tdata[1:0];
      item.value     <= s_tdata[9:2];
      item.now       <= s_tdata[73:10];
    end
  end

  itrg_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .period      (period),
    .result      (result),
    .count0_next (count0_next)
  );

  itrg_period u_period (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .count0_next (count0_next),
    .period      (period)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign m_tdata = {3'b000, result_q.error_code, result_q.time_left, result_q.irq_action};

endmodule

// ===== bench/interval_timer_rate_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_timer_rate_generator_tb
// Self-checking bench for the three-channel interval timer. A scoreboard
// class tracks the channel state and the scale register. It predicts the
// interrupt action, the time left and the error code of every input transfer,
// and it checks each output transfer against the oldest prediction. The
// stimulus starts with command, data and query cases, then sends random
// programming sequences, queries and noise under several scale settings.
// Both sides idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module interval_timer_rate_generator_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_AFTER = 300;
  localparam int PRESSURE_CYCLES = 400;

  class timer_scoreboard;
    logic [itrg_pkg::SCALE_W-1:0] scale;
    logic [2:0]                   op_mode [itrg_pkg::NUM_CHANNELS];
    logic [1:0]                   acc_mode [itrg_pkg::NUM_CHANNELS];
    bit                           lo_done [itrg_pkg::NUM_CHANNELS];
    logic [itrg_pkg::COUNT_W-1:0] count [itrg_pkg::NUM_CHANNELS];
    bit                           running [itrg_pkg::NUM_CHANNELS];
    logic [itrg_pkg::TIME_W-1:0]  last_irq;
    itrg_pkg::result_t            pending_results [$];
    int                           mismatches;

    function new();
      scale = itrg_pkg::SCALE_RESET;
      for (int i = 0; i < itrg_pkg::NUM_CHANNELS; i++) begin
        op_mode[i] = '0;
        acc_mode[i] = '0;
        lo_done[i] = 1'b0;
        count[i] = '0;
        running[i] = 1'b0;
      end
      last_irq = '0;
      mismatches = 0;
    endfunction

    function logic [itrg_pkg::TIME_W-1:0] ch0_period();
      logic [itrg_pkg::TIME_W-1:0] cnt;
      cnt = (count[0] == '0) ? 64'd65536 : {48'd0, count[0]};
      return (cnt * {32'd0, scale}) >> 16;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void predict_transfer(itrg_pkg::item_t it);
      itrg_pkg::result_t r;
      logic [itrg_pkg::TIME_W-1:0] p;
      logic [1:0] ch;
      logic [1:0] acc;
      logic [2:0] mode;
      r.irq_action = itrg_pkg::IRQ_NONE;
      r.time_left = '0;
      r.error_code = itrg_pkg::ERR_OK;
      if (it.operation == itrg_pkg::OP_QUERY) begin
        if (running[0]) begin
          p = ch0_period();
          if (it.now - last_irq >= p) begin
            last_irq = it.now;
            r.time_left = p;
            r.irq_action = itrg_pkg::IRQ_PULSE;
          end else begin
            r.time_left = last_irq + p - it.now;
          end
        end else begin
          r.time_left = '1;
        end
      end else if (it.port == itrg_pkg::PORT_CMD) begin
        ch = it.value[7:6];
        acc = it.value[5:4];
        mode = it.value[3:1];
        if (ch == itrg_pkg::CH_READBACK) begin
          r.error_code = itrg_pkg::ERR_READBACK;
        end else if (acc == itrg_pkg::ACC_LATCH) begin
          r.error_code = itrg_pkg::ERR_LATCH;
        end else if (it.value[0]) begin
          r.error_code = itrg_pkg::ERR_BCD;
        end else if (ch < itrg_pkg::NUM_CHANNELS) begin
          acc_mode[ch] = acc;
          op_mode[ch] = mode;
          lo_done[ch] = 1'b0;
          if (mode == itrg_pkg::MODE_RATE && ch == 2'd0) r.irq_action = itrg_pkg::IRQ_RAISE;
        end
      end else if (it.port < itrg_pkg::NUM_CHANNELS) begin
        if (acc_mode[it.port] != itrg_pkg::ACC_LOHI) begin
          r.error_code = itrg_pkg::ERR_ACCESS;
        end else if (lo_done[it.port]) begin
          count[it.port][15:8] = it.value;
          running[it.port] = 1'b1;
          lo_done[it.port] = 1'b0;
          if (it.port == 2'd0) last_irq = it.now;
        end else begin
          count[it.port] = {8'h00, it.value};
          lo_done[it.port] = 1'b1;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [71:0] data);
      itrg_pkg::result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result irq=%0d left=%h err=%0d",
                   data[1:0], data[65:2], data[68:66]);
        return;
      end
      e = pending_results.pop_front();
      if (data[1:0] !== e.irq_action || data[65:2] !== e.time_left ||
          data[68:66] !== e.error_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp irq=%0d left=%h err=%0d, got irq=%0d left=%h err=%0d",
                   e.irq_action, e.time_left, e.error_code,
                   data[1:0], data[65:2], data[68:66]);
      end
    endfunction

    function void flag_leftovers();
      if (pending_results.size() != 0) begin
        mismatches += pending_results.size();
        $display("mismatch: %0d results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wen = 1'b0;
  logic [itrg_pkg::SCALE_W-1:0] cfg_wdata = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [79:0]                  s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [71:0]                  m_tdata;

  timer_scoreboard              sb = new();
  logic [itrg_pkg::TIME_W-1:0]  t_base = '0;
  int                           sent = 0;
  int                           tx_calm = 0;
  int                           rx_calm = 0;

  interval_timer_rate_generator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the time base, mostly around the channel 0 period.
  function automatic logic [itrg_pkg::TIME_W-1:0] advance_now();
    logic [itrg_pkg::TIME_W-1:0] p;
    logic [itrg_pkg::TIME_W-1:0] d;
    int r;
    p = sb.ch0_period();
    r = $urandom_range(0, 99);
    d = '0;
    if (r < 55) begin
      d = {$urandom, $urandom} % (2 * p + 2);
    end else if (r < 75) begin
      t_base = sb.last_irq + p - 1;
      d = $urandom_range(0, 2);
    end else if (r < 88) begin
      d = $urandom_range(0, 3);
    end else if (r < 95) begin
      t_base = {$urandom, $urandom};
    end else begin
      t_base = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 64);
    end
    t_base = t_base + d;
    return t_base;
  endfunction

  task automatic send_item(input itrg_pkg::op_t op, input logic [1:0] port,
                           input logic [7:0] value,
                           input logic [itrg_pkg::TIME_W-1:0] now);
    int gap;
    itrg_pkg::item_t it;
    gap = pick_gap(tx_calm);
    it.operation = op;
    it.port = port;
    it.value = value;
    it.now = now;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'd0, now, value, port};
    do @(posedge clk); while (!s_tready);
    sb.predict_transfer(it);
    sent++;
  endtask

  task automatic send_query(input logic [itrg_pkg::TIME_W-1:0] now);
    send_item(itrg_pkg::OP_QUERY, 2'($urandom), 8'($urandom), now);
  endtask

  task automatic send_write(input logic [1:0] port, input logic [7:0] value,
                            input logic [itrg_pkg::TIME_W-1:0] now);
    send_item(itrg_pkg::OP_WRITE, port, value, now);
  endtask

  task automatic send_program();
    logic [1:0] ch;
    logic [2:0] mode;
    logic [7:0] hi;
    ch = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 1)) ch = 2'd0;
    mode = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : itrg_pkg::MODE_RATE;
    hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    send_write(itrg_pkg::PORT_CMD, {ch, itrg_pkg::ACC_LOHI, mode, 1'b0}, advance_now());
    send_write(ch, 8'($urandom), advance_now());
    send_write(ch, hi, advance_now());
  endtask

  task automatic run_random(input int n);
    int stop;
    int r;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_query(advance_now());
      end else if (r < 75) begin
        send_program();
      end else if (r < 85) begin
        send_write(2'($urandom_range(0, 2)), 8'($urandom), advance_now());
      end else begin
        send_item(itrg_pkg::op_t'($urandom_range(0, 1)), 2'($urandom), 8'($urandom),
                  $urandom_range(0, 1) ? {$urandom, $urandom} : advance_now());
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_scale(input logic [itrg_pkg::SCALE_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    sb.scale = v;
  endtask

  task automatic run_directed();
    logic [itrg_pkg::TIME_W-1:0] p;
    send_query(64'd5);
    send_write(2'd0, 8'h12, 64'd6);
    send_write(itrg_pkg::PORT_CMD, 8'hC0, 64'd7);
    send_write(itrg_pkg::PORT_CMD, 8'hFF, 64'd7);
    send_write(itrg_pkg::PORT_CMD, 8'h00, 64'd8);
    send_write(itrg_pkg::PORT_CMD, 8'h35, 64'd9);
    send_write(itrg_pkg::PORT_CMD, 8'h34, 64'd10);
    send_write(2'd0, 8'h00, 64'd20);
    send_write(2'd0, 8'h00, 64'd100);
    p = sb.ch0_period();
    send_query(64'd100);
    send_query(64'd100 + p - 1);
    send_query(64'd100 + p);
    send_query(64'd100 + p + 1);
    send_write(itrg_pkg::PORT_CMD, 8'h14, 64'd200);
    send_write(2'd0, 8'hAA, 64'd201);
    send_write(itrg_pkg::PORT_CMD, 8'h76, 64'd202);
    send_write(2'd1, 8'hFF, 64'd203);
    send_write(2'd1, 8'hFF, 64'd204);
    send_write(itrg_pkg::PORT_CMD, 8'hB6, 64'd205);
    send_write(2'd2, 8'h12, 64'd206);
    send_write(2'd2, 8'h34, 64'd207);
    send_write(itrg_pkg::PORT_CMD, 8'h30, 64'd208);
    send_write(2'd0, 8'hFF, 64'hFFFF_FFFF_FFFF_FF00);
    send_write(2'd0, 8'hFF, 64'hFFFF_FFFF_FFFF_FF00);
    send_query(64'h0000_0000_0000_0010);
    send_query(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Receiver: random ready gaps, plus one long hold-off to back up the input.
  initial begin
    int stall;
    int seen;
    int gap;
    bit pressure_done;
    stall = 0;
    seen = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && seen >= PRESSURE_AFTER) begin
        stall = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        gap = pick_gap(rx_calm);
        if (gap > 0) begin
          m_tready <= 1'b0;
          stall = gap - 1;
        end else begin
          m_tready <= 1'b1;
        end
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        seen++;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("FAIL interval_timer_rate_generator");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    load_scale(itrg_pkg::SCALE_RESET);
    run_directed();
    run_random(500);
    load_scale(32'hFFFF_FFFF);
    run_random(350);
    load_scale(32'd1);
    run_random(350);
    load_scale(32'd65536);
    run_random(350);
    load_scale($urandom_range(1, 32'hFFFF_FFFF));
    run_random(400);
    drain();
    repeat (8) @(posedge clk);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("PASS interval_timer_rate_generator");
    end else begin
      $display("FAIL interval_timer_rate_generator");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/itrg_pkg.sv
rtl/itrg_period.sv
rtl/itrg_core.sv
rtl/interval_timer_rate_generator.sv
bench/interval_timer_rate_generator_tb.sv
